// File: rtl/framebuffer_pixel_write_unit_macros.svh
`ifndef FRAMEBUFFER_PIXEL_WRITE_UNIT_MACROS_SVH
`define FRAMEBUFFER_PIXEL_WRITE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and masked while arst_n is low.
`define FBPW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and masked while arst_n is low.
`define FBPW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/fbpw_pkg.sv
package fbpw_pkg;

	localparam int COORD_W    = 16;
	localparam int CHAN_W     = 8;
	localparam int ADDR_W     = 32;
	localparam int DATA_W     = 32;
	localparam int BYTES_W    = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int RES_W      = 16;
	localparam int STRIDE_W   = 18;
	localparam int BPP_W      = 8;
	localparam int MEM_W      = 32;
	localparam int FIELDS_W   = 20;
	localparam int FLD_W      = 5;
	localparam int LEN_MAX    = 16;
	localparam int NUM_W      = 24;
	localparam int ADDR_EXT_W = 33;

	localparam logic [RES_W-1:0]    X_RES_RST    = 16'd800;
	localparam logic [RES_W-1:0]    Y_RES_RST    = 16'd480;
	localparam logic [STRIDE_W-1:0] STRIDE_RST   = 18'd3200;
	localparam logic [BPP_W-1:0]    BPP_RST      = 8'd32;
	localparam logic [MEM_W-1:0]    MEM_SIZE_RST = 32'd1536000;
	localparam logic [FIELDS_W-1:0] LENGTHS_RST  = 20'd8456;
	localparam logic [FIELDS_W-1:0] OFFSETS_RST  = 20'd786704;

	// The quotient by 255 is the top bits of the product with ceil(2^32 / 255),
	// exact for every numerator that a 16-bit channel can produce.
	localparam int                  RECIP_SHIFT  = 32;
	localparam logic [24:0]         RECIP_255    = 25'd16843010;
	localparam logic [NUM_W-1:0]    ROUND_BIAS   = 24'd127;

	localparam logic [BYTES_W-1:0]  BYTES_MIN    = 3'd2;
	localparam logic [BYTES_W-1:0]  BYTES_MAX    = 3'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_RES    = 3'd0,
		REG_Y_RES    = 3'd1,
		REG_STRIDE   = 3'd2,
		REG_BPP      = 3'd3,
		REG_MEM_SIZE = 3'd4,
		REG_LENGTHS  = 3'd5,
		REG_OFFSETS  = 3'd6
	} cfg_reg_t;

	function automatic logic [FLD_W-1:0] sat_len(input logic [FLD_W-1:0] len);
		return (len > FLD_W'(LEN_MAX)) ? FLD_W'(LEN_MAX) : len;
	endfunction

	// v * (2^len - 1) + 127, written as a shift and a subtract.
	function automatic logic [NUM_W-1:0] scale_num(input logic [CHAN_W-1:0] v,
		input logic [FLD_W-1:0] len);
		logic [NUM_W-1:0] w;
		w = NUM_W'(v) << sat_len(len);
		return w - NUM_W'(v) + ROUND_BIAS;
	endfunction

	function automatic logic [LEN_MAX-1:0] chan_max(input logic [FLD_W-1:0] len);
		logic [LEN_MAX:0] one;
		one = (LEN_MAX+1)'(1) << sat_len(len);
		return LEN_MAX'(one - (LEN_MAX+1)'(1));
	endfunction

	function automatic logic [DATA_W-1:0] place(input logic [LEN_MAX-1:0] q,
		input logic [FLD_W-1:0] off);
		return DATA_W'(q) << off;
	endfunction

endpackage

// File: rtl/fbpw_if.sv
interface fbpw_pix_if import fbpw_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] pos_x;
	logic signed [COORD_W-1:0] pos_y;
	logic [CHAN_W-1:0]         red_in;
	logic [CHAN_W-1:0]         green_in;
	logic [CHAN_W-1:0]         blue_in;

	modport source (output valid, output pos_x, output pos_y, output red_in,
		output green_in, output blue_in, input ready);
	modport sink (input valid, input pos_x, input pos_y, input red_in,
		input green_in, input blue_in, output ready);
endinterface

interface fbpw_wr_if import fbpw_pkg::*;;
	logic               valid;
	logic               ready;
	logic [ADDR_W-1:0]  write_address;
	logic [DATA_W-1:0]  write_data;
	logic [BYTES_W-1:0] write_bytes;

	modport source (output valid, output write_address, output write_data,
		output write_bytes, input ready);
	modport sink (input valid, input write_address, input write_data,
		input write_bytes, output ready);
endinterface

// File: rtl/framebuffer_pixel_write_unit.sv
// Pixel write unit: turns each accepted pixel request into one framebuffer memory write, or
// into nothing when the pixel is off screen, the pixel size is not 2, 3 or 4 bytes, or the
// write would run past the end of memory. It is a four-stage pipeline (checks and channel
// scaling numerators, multipliers, address sum and packing, memory bound check into the
// output register) that accepts one item every clock unless back-pressure has filled it;
// each item goes through stages 1, 2 and 3 into the output register. Back-pressure on the
// output stalls only the stages that hold items, so empty stages still fill. The user must
// write configuration only while the pipeline is empty; the block does not enforce this.
`include "framebuffer_pixel_write_unit_macros.svh"

module framebuffer_pixel_write_unit import fbpw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	fbpw_pix_if.sink              pix_in,
	fbpw_wr_if.source             wr_out
);

	logic [RES_W-1:0]    x_res_q;
	logic [RES_W-1:0]    y_res_q;
	logic [STRIDE_W-1:0] stride_q;
	logic [BPP_W-1:0]    bpp_q;
	logic [MEM_W-1:0]    mem_size_q;
	logic [FIELDS_W-1:0] lengths_q;
	logic [FIELDS_W-1:0] offsets_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_res_q    <= X_RES_RST;
			y_res_q    <= Y_RES_RST;
			stride_q   <= STRIDE_RST;
			bpp_q      <= BPP_RST;
			mem_size_q <= MEM_SIZE_RST;
			lengths_q  <= LENGTHS_RST;
			offsets_q  <= OFFSETS_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_X_RES:    x_res_q    <= cfg_wdata[RES_W-1:0];
				REG_Y_RES:    y_res_q    <= cfg_wdata[RES_W-1:0];
				REG_STRIDE:   stride_q   <= cfg_wdata[STRIDE_W-1:0];
				REG_BPP:      bpp_q      <= cfg_wdata[BPP_W-1:0];
				REG_MEM_SIZE: mem_size_q <= cfg_wdata[MEM_W-1:0];
				REG_LENGTHS:  lengths_q  <= cfg_wdata[FIELDS_W-1:0];
				REG_OFFSETS:  offsets_q  <= cfg_wdata[FIELDS_W-1:0];
				default: ;
			endcase
		end
	end

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;
	logic ok_s3;
	logic fits;

	assign en4 = !v_s4 || wr_out.ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign pix_in.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= pix_in.valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3 && ok_s3 && fits;
			end
		end
	end

	// Stage 1: screen and pixel size checks, scaling numerators.
	logic [BPP_W-4:0]   bpp_whole;
	logic               ok_in;
	logic               ok_s1;
	logic [COORD_W-2:0] xs_s1;
	logic [COORD_W-2:0] ys_s1;
	logic [BYTES_W-1:0] bpp_s1;
	logic [NUM_W-1:0]   num_r_s1;
	logic [NUM_W-1:0]   num_g_s1;
	logic [NUM_W-1:0]   num_b_s1;
	logic [LEN_MAX-1:0] alpha_s1;

	assign bpp_whole = bpp_q[BPP_W-1:3];
	assign ok_in = !pix_in.pos_x[COORD_W-1] && !pix_in.pos_y[COORD_W-1]
		&& ($unsigned(pix_in.pos_x) < x_res_q) && ($unsigned(pix_in.pos_y) < y_res_q)
		&& (bpp_whole >= (BPP_W-3)'(BYTES_MIN)) && (bpp_whole <= (BPP_W-3)'(BYTES_MAX));

	always_ff @(posedge clk) begin
		if (en1) begin
			ok_s1    <= ok_in;
			xs_s1    <= pix_in.pos_x[COORD_W-2:0];
			ys_s1    <= pix_in.pos_y[COORD_W-2:0];
			bpp_s1   <= bpp_whole[BYTES_W-1:0];
			num_r_s1 <= scale_num(pix_in.red_in, lengths_q[FLD_W-1:0]);
			num_g_s1 <= scale_num(pix_in.green_in, lengths_q[2*FLD_W-1:FLD_W]);
			num_b_s1 <= scale_num(pix_in.blue_in, lengths_q[3*FLD_W-1:2*FLD_W]);
			alpha_s1 <= chan_max(lengths_q[4*FLD_W-1:3*FLD_W]);
		end
	end

	// Stage 2: line and column products, division of each numerator by 255.
	logic [ADDR_EXT_W-1:0] line_prod;
	logic [COORD_W+1:0]    col_prod;
	logic [48:0]           rq, gq, bq;
	logic                  ok_s2;
	logic [BYTES_W-1:0]    bpp_s2;
	logic [ADDR_EXT_W-1:0] line_s2;
	logic [COORD_W+1:0]    col_s2;
	logic [LEN_MAX-1:0]    q_r_s2, q_g_s2, q_b_s2, alpha_s2;

	assign line_prod = ys_s1 * stride_q;
	assign col_prod  = xs_s1 * bpp_s1;
	assign rq        = num_r_s1 * RECIP_255;
	assign gq        = num_g_s1 * RECIP_255;
	assign bq        = num_b_s1 * RECIP_255;

	always_ff @(posedge clk) begin
		if (en2) begin
			ok_s2    <= ok_s1;
			bpp_s2   <= bpp_s1;
			line_s2  <= line_prod;
			col_s2   <= col_prod;
			q_r_s2   <= rq[RECIP_SHIFT+LEN_MAX-1:RECIP_SHIFT];
			q_g_s2   <= gq[RECIP_SHIFT+LEN_MAX-1:RECIP_SHIFT];
			q_b_s2   <= bq[RECIP_SHIFT+LEN_MAX-1:RECIP_SHIFT];
			alpha_s2 <= alpha_s1;
		end
	end

	// Stage 3: byte address and packed pixel word.
	logic [BYTES_W-1:0]    bpp_s3;
	logic [ADDR_EXT_W-1:0] addr_s3;
	logic [DATA_W-1:0]     data_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			ok_s3   <= ok_s2;
			bpp_s3  <= bpp_s2;
			addr_s3 <= line_s2 + ADDR_EXT_W'(col_s2);
			data_s3 <= place(q_r_s2, offsets_q[FLD_W-1:0])
				| place(q_g_s2, offsets_q[2*FLD_W-1:FLD_W])
				| place(q_b_s2, offsets_q[3*FLD_W-1:2*FLD_W])
				| place(alpha_s2, offsets_q[4*FLD_W-1:3*FLD_W]);
		end
	end

	// Stage 4: memory bound check into the output register.
	logic [ADDR_W-1:0]  addr_s4;
	logic [DATA_W-1:0]  data_s4;
	logic [BYTES_W-1:0] bytes_s4;

	assign fits = (addr_s3 + ADDR_EXT_W'(bpp_s3)) <= ADDR_EXT_W'(mem_size_q);

	always_ff @(posedge clk) begin
		if (en4) begin
			addr_s4  <= addr_s3[ADDR_W-1:0];
			data_s4  <= data_s3;
			bytes_s4 <= bpp_s3;
		end
	end

	assign wr_out.valid         = v_s4;
	assign wr_out.write_address = addr_s4;
	assign wr_out.write_data    = data_s4;
	assign wr_out.write_bytes   = bytes_s4;

	`FBPW_ASSERT_NOW(a_bytes_range, wr_out.valid,
		(wr_out.write_bytes == BYTES_MIN) || (wr_out.write_bytes == 3'd3)
		|| (wr_out.write_bytes == BYTES_MAX), "write size outside 2 to 4 bytes")
	`FBPW_ASSERT_NOW(a_in_memory, wr_out.valid,
		(ADDR_EXT_W'(wr_out.write_address) + ADDR_EXT_W'(wr_out.write_bytes))
		<= ADDR_EXT_W'(mem_size_q), "write runs past end of memory")
	`FBPW_ASSERT_NOW(a_empty_ready, !v_s1, pix_in.ready, "input stalled with empty first stage")
	`FBPW_ASSERT_NEXT(a_accept_lands, pix_in.valid && pix_in.ready, v_s1,
		"accepted item missing in first stage")

endmodule

// File: sim/testbench.sv
module testbench import fbpw_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int DRAIN_PAUSE = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int REPORT_LIMIT = 40;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [CHAN_W-1:0]         red;
		logic [CHAN_W-1:0]         green;
		logic [CHAN_W-1:0]         blue;
	} pixel_req_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  address;
		logic [DATA_W-1:0]  data;
		logic [BYTES_W-1:0] nbytes;
	} mem_write_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	fbpw_pix_if pix();
	fbpw_wr_if  wr();

	framebuffer_pixel_write_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pix_in    (pix),
		.wr_out    (wr)
	);

	logic [RES_W-1:0]    cur_width   = X_RES_RST;
	logic [RES_W-1:0]    cur_height  = Y_RES_RST;
	logic [STRIDE_W-1:0] cur_stride  = STRIDE_RST;
	logic [BPP_W-1:0]    cur_bpp     = BPP_RST;
	logic [MEM_W-1:0]    cur_mem     = MEM_SIZE_RST;
	logic [FIELDS_W-1:0] cur_lengths = LENGTHS_RST;
	logic [FIELDS_W-1:0] cur_offsets = OFFSETS_RST;

	mem_write_t expected_writes[$];

	int error_count = 0;
	int cycle_count = 0;
	int pixels_sent = 0;
	int pixels_dropped = 0;
	int writes_checked = 0;
	int settings_applied = 0;
	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	int unsigned hold_request = 0;
	int unsigned hold_left = 0;

	always #5 clk = ~clk;

	function automatic logic [DATA_W-1:0] channel_field(input logic [CHAN_W-1:0] level,
		input logic [FLD_W-1:0] len, input logic [FLD_W-1:0] off);
		int unsigned bits;
		logic [31:0] scaled;
		logic [63:0] shifted;
		if (len == 0) begin
			return '0;
		end
		bits = (len > LEN_MAX) ? LEN_MAX : len;
		scaled = (32'(level) * ((32'd1 << bits) - 32'd1) + 32'd127) / 32'd255;
		shifted = 64'(scaled) << off;
		return shifted[31:0];
	endfunction

	function automatic bit predict_write(input pixel_req_t p, output mem_write_t w);
		logic [63:0] addr;
		logic [DATA_W-1:0] packed_pix;
		int unsigned nbytes;
		w = '0;
		if (p.x[COORD_W-1] || p.y[COORD_W-1]) begin
			return 1'b0;
		end
		if ($unsigned(p.x) >= cur_width || $unsigned(p.y) >= cur_height) begin
			return 1'b0;
		end
		nbytes = cur_bpp / 8;
		if (nbytes < 2 || nbytes > 4) begin
			return 1'b0;
		end
		addr = 64'($unsigned(p.y)) * 64'(cur_stride) + 64'($unsigned(p.x)) * 64'(nbytes);
		if (addr + 64'(nbytes) > 64'(cur_mem)) begin
			return 1'b0;
		end
		packed_pix = channel_field(p.red, cur_lengths[4:0], cur_offsets[4:0])
			| channel_field(p.green, cur_lengths[9:5], cur_offsets[9:5])
			| channel_field(p.blue, cur_lengths[14:10], cur_offsets[14:10]);
		if (cur_lengths[19:15] != 0) begin
			packed_pix |= channel_field(8'hFF, cur_lengths[19:15], cur_offsets[19:15]);
		end
		w.address = addr[31:0];
		w.data = packed_pix;
		w.nbytes = BYTES_W'(nbytes);
		return 1'b1;
	endfunction

	function automatic logic [FIELDS_W-1:0] pack_fields(input logic [FLD_W-1:0] r,
		input logic [FLD_W-1:0] g, input logic [FLD_W-1:0] b, input logic [FLD_W-1:0] a);
		return {a, b, g, r};
	endfunction

	function automatic pixel_req_t pixel_at(input int x, input int y,
		input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
		pixel_req_t p;
		p.x = COORD_W'(x);
		p.y = COORD_W'(y);
		p.red = r;
		p.green = g;
		p.blue = b;
		return p;
	endfunction

	function automatic pixel_req_t random_pixel();
		pixel_req_t p;
		int unsigned x_span;
		int unsigned y_span;
		int unsigned pick;
		x_span = (cur_width > 32768) ? 32768 : int'(cur_width);
		y_span = (cur_height > 32768) ? 32768 : int'(cur_height);
		pick = $urandom_range(99);
		p.red = CHAN_W'($urandom);
		p.green = CHAN_W'($urandom);
		p.blue = CHAN_W'($urandom);
		p.x = (x_span != 0) ? COORD_W'($urandom_range(0, x_span - 1)) : '0;
		p.y = (y_span != 0) ? COORD_W'($urandom_range(0, y_span - 1)) : '0;
		if (pick >= 95) begin
			p.y = COORD_W'(cur_height) - COORD_W'($urandom_range(0, 1));
		end else if (pick >= 90) begin
			p.x = COORD_W'(cur_width) - COORD_W'($urandom_range(0, 1));
		end else if (pick >= 80) begin
			p.x = COORD_W'($urandom);
			p.y = COORD_W'($urandom);
		end
		return p;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		error_count++;
		if (error_count <= REPORT_LIMIT) begin
			$display("Mismatch at cycle %0d: %s is 0x%08h, expected 0x%08h",
				cycle_count, what, got, want);
		end
	endtask

	task automatic set_idling(input int src_pct, input int snk_pct);
		src_idle_pct = src_pct;
		snk_stall_pct = snk_pct;
	endtask

	task automatic send_pixel(input pixel_req_t p);
		mem_write_t w;
		while ($urandom_range(99) < src_idle_pct) begin
			pix.valid <= 1'b0;
			@(negedge clk);
		end
		pix.valid <= 1'b1;
		pix.pos_x <= p.x;
		pix.pos_y <= p.y;
		pix.red_in <= p.red;
		pix.green_in <= p.green;
		pix.blue_in <= p.blue;
		do @(posedge clk); while (pix.ready !== 1'b1);
		pixels_sent++;
		if (predict_write(p, w)) begin
			expected_writes.push_back(w);
		end else begin
			pixels_dropped++;
		end
		@(negedge clk);
	endtask

	task automatic wait_for_idle();
		pix.valid <= 1'b0;
		while (expected_writes.size() != 0) @(negedge clk);
		repeat (DRAIN_PAUSE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		wait_for_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			REG_X_RES:    cur_width = value[RES_W-1:0];
			REG_Y_RES:    cur_height = value[RES_W-1:0];
			REG_STRIDE:   cur_stride = value[STRIDE_W-1:0];
			REG_BPP:      cur_bpp = value[BPP_W-1:0];
			REG_MEM_SIZE: cur_mem = value[MEM_W-1:0];
			REG_LENGTHS:  cur_lengths = value[FIELDS_W-1:0];
			REG_OFFSETS:  cur_offsets = value[FIELDS_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all_regs(input logic [RES_W-1:0] w, input logic [RES_W-1:0] h,
		input logic [STRIDE_W-1:0] stride, input logic [BPP_W-1:0] bpp,
		input logic [MEM_W-1:0] mem, input logic [FIELDS_W-1:0] lengths,
		input logic [FIELDS_W-1:0] offsets);
		write_reg(REG_X_RES, CFG_DATA_W'(w));
		write_reg(REG_Y_RES, CFG_DATA_W'(h));
		write_reg(REG_STRIDE, CFG_DATA_W'(stride));
		write_reg(REG_BPP, CFG_DATA_W'(bpp));
		write_reg(REG_MEM_SIZE, CFG_DATA_W'(mem));
		write_reg(REG_LENGTHS, CFG_DATA_W'(lengths));
		write_reg(REG_OFFSETS, CFG_DATA_W'(offsets));
		settings_applied++;
	endtask

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++) begin
			send_pixel(random_pixel());
		end
	endtask

	task automatic test_directed_cases();
		set_idling(0, 0);
		send_pixel(pixel_at(0, 0, 8'h00, 8'h00, 8'h00));
		send_pixel(pixel_at(799, 479, 8'hFF, 8'hFF, 8'hFF));
		send_pixel(pixel_at(800, 0, 8'h10, 8'h20, 8'h30));
		send_pixel(pixel_at(0, 480, 8'h10, 8'h20, 8'h30));
		send_pixel(pixel_at(-1, 5, 8'h40, 8'h50, 8'h60));
		send_pixel(pixel_at(5, -32768, 8'h40, 8'h50, 8'h60));
		send_pixel(pixel_at(32767, 32767, 8'hFF, 8'h00, 8'hFF));
		send_pixel(pixel_at(1, 1, 8'h01, 8'h80, 8'hFE));
		send_pixel(pixel_at(400, 240, 8'h7F, 8'h80, 8'h81));
		write_reg(REG_UNUSED, '0);
		send_pixel(pixel_at(10, 10, 8'hAA, 8'h55, 8'h0F));
		write_reg(REG_BPP, 32'd8);
		send_pixel(pixel_at(0, 0, 8'h11, 8'h22, 8'h33));
		write_reg(REG_BPP, 32'd40);
		send_pixel(pixel_at(0, 0, 8'h11, 8'h22, 8'h33));
		write_reg(REG_BPP, 32'd23);
		send_pixel(pixel_at(3, 7, 8'h11, 8'h22, 8'h33));
		write_reg(REG_BPP, 32'd255);
		send_pixel(pixel_at(3, 7, 8'h11, 8'h22, 8'h33));
		write_reg(REG_BPP, 32'd32);
		write_reg(REG_MEM_SIZE, 32'd1535999);
		send_pixel(pixel_at(799, 479, 8'hC0, 8'hC1, 8'hC2));
		send_pixel(pixel_at(798, 479, 8'hC0, 8'hC1, 8'hC2));
		write_reg(REG_LENGTHS, CFG_DATA_W'(pack_fields(31, 31, 31, 31)));
		write_reg(REG_OFFSETS, CFG_DATA_W'(pack_fields(0, 16, 24, 31)));
		send_pixel(pixel_at(2, 3, 8'hFF, 8'h00, 8'h80));
		send_pixel(pixel_at(3, 2, 8'h01, 8'hFF, 8'hFE));
		write_reg(REG_LENGTHS, CFG_DATA_W'(pack_fields(0, 8, 8, 1)));
		write_reg(REG_OFFSETS, CFG_DATA_W'(pack_fields(0, 8, 16, 31)));
		send_pixel(pixel_at(4, 4, 8'hC8, 8'h64, 8'h32));
		send_pixel(pixel_at(5, 5, 8'hFF, 8'hFF, 8'hFF));
	endtask

	task automatic test_default_stream();
		write_all_regs(X_RES_RST, Y_RES_RST, STRIDE_RST, BPP_RST, MEM_SIZE_RST,
			LENGTHS_RST, OFFSETS_RST);
		set_idling(0, 0);
		run_random(300);
	endtask

	task automatic test_rgb565();
		write_all_regs(16'd640, 16'd480, 18'd1280, 8'd16, 32'd614400,
			pack_fields(5, 6, 5, 0), pack_fields(11, 5, 0, 0));
		set_idling(59, 0);
		run_random(250);
	endtask

	task automatic test_rgb888();
		write_all_regs(16'd1024, 16'd600, 18'd3072, 8'd24, 32'd1843100,
			pack_fields(8, 8, 8, 0), pack_fields(16, 8, 0, 0));
		set_idling(0, 59);
		run_random(250);
	endtask

	task automatic test_extreme_settings();
		write_all_regs(16'hFFFF, 16'hFFFF, 18'h3FFFF, 8'd39, 32'hFFFF_FFFF,
			pack_fields(31, 31, 31, 31), pack_fields(0, 10, 20, 31));
		set_idling(18, 18);
		run_random(200);
	endtask

	task automatic test_all_zero();
		write_all_regs('0, '0, '0, '0, '0, '0, '0);
		set_idling(18, 18);
		run_random(30);
	endtask

	task automatic test_random_settings();
		logic [RES_W-1:0] w;
		logic [RES_W-1:0] h;
		logic [STRIDE_W-1:0] stride;
		logic [BPP_W-1:0] bpp;
		logic [MEM_W-1:0] mem;
		for (int k = 0; k < 6; k++) begin
			case (k % 4)
				0: set_idling(0, 0);
				1: set_idling(59, 0);
				2: set_idling(0, 59);
				default: set_idling(18, 18);
			endcase
			w = ($urandom_range(3) == 0) ? RES_W'($urandom) : RES_W'($urandom_range(1, 1024));
			h = ($urandom_range(3) == 0) ? RES_W'($urandom) : RES_W'($urandom_range(1, 1024));
			stride = ($urandom_range(3) == 0) ? STRIDE_W'($urandom)
				: STRIDE_W'($urandom_range(0, 4096));
			bpp = ($urandom_range(4) == 0) ? BPP_W'($urandom)
				: BPP_W'(8 * $urandom_range(2, 4) + $urandom_range(0, 7));
			mem = ($urandom_range(3) == 0) ? MEM_W'($urandom)
				: MEM_W'($urandom_range(1 << 20, 1 << 23));
			write_all_regs(w, h, stride, bpp, mem, FIELDS_W'($urandom), FIELDS_W'($urandom));
			run_random(80);
		end
	endtask

	task automatic test_output_hold();
		write_all_regs(X_RES_RST, Y_RES_RST, STRIDE_RST, BPP_RST, MEM_SIZE_RST,
			LENGTHS_RST, OFFSETS_RST);
		set_idling(0, 0);
		hold_request = HOLD_CYCLES;
		run_random(60);
	endtask

	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			wr.ready <= 1'b0;
		end else begin
			wr.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	always @(posedge clk) begin
		mem_write_t want;
		if (arst_n && wr.valid === 1'b1 && wr.ready === 1'b1) begin
			if (expected_writes.size() == 0) begin
				report_mismatch("unexpected write address", wr.write_address, '0);
			end else begin
				want = expected_writes.pop_front();
				writes_checked++;
				if (wr.write_address !== want.address) begin
					report_mismatch("write_address", wr.write_address, want.address);
				end
				if (wr.write_data !== want.data) begin
					report_mismatch("write_data", wr.write_data, want.data);
				end
				if (wr.write_bytes !== want.nbytes) begin
					report_mismatch("write_bytes", 32'(wr.write_bytes), 32'(want.nbytes));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d writes still outstanding.",
				cycle_count, expected_writes.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		pix.valid = 1'b0;
		pix.pos_x = '0;
		pix.pos_y = '0;
		pix.red_in = '0;
		pix.green_in = '0;
		pix.blue_in = '0;
		wr.ready = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_cases();
		test_default_stream();
		test_rgb565();
		test_rgb888();
		test_extreme_settings();
		test_all_zero();
		test_random_settings();
		test_output_hold();
		wait_for_idle();

		$display("Sent %0d pixel requests across %0d full register settings.",
			pixels_sent, settings_applied);
		$display("%0d writes checked, %0d dropped; 16, 24 and 32 bit pixels, %s %0d cycles.",
			writes_checked, pixels_dropped, "clipping, memory bounds and an output hold of",
			HOLD_CYCLES);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// File: framebuffer_pixel_write_unit.f
+incdir+rtl
rtl/fbpw_pkg.sv
rtl/fbpw_if.sv
rtl/framebuffer_pixel_write_unit.sv
sim/testbench.sv
